FILE: hdl/assert_macros.svh
// Assertion macros shared by the edit distance RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Checks that the consequent holds in the same cycle as the antecedent.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(lbl, expr, msg)
`define CHK_IMPL(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/edm_pkg.sv
// Types, constants and helper functions of the edit distance best match unit.
`default_nettype none

package edm_pkg;

  localparam int CHAR_W = 8;
  localparam int DIST_W = 7;
  localparam int TIE_W  = 10;
  localparam int CFG_W  = 6;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 32;

  localparam logic [DIST_W-1:0] DIST_MAX     = 7'd127;
  localparam logic [TIE_W-1:0]  TIE_MAX      = 10'd1023;
  localparam logic [CFG_W-1:0]  MAXD_RESET   = 6'd2;
  localparam logic [DIST_W-1:0] BEST_RESET   = 7'd3;
  localparam logic [DIST_W-1:0] BEST_LIMIT   = 7'd64;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_CAND    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    VERDICT_SKIP = 2'd0,
    VERDICT_BEST = 2'd1,
    VERDICT_TIE  = 2'd2,
    VERDICT_WORSE = 2'd3
  } verdict_t;

  // One candidate item traveling down the cell row.
  typedef struct packed {
    logic              start;     // row starts fresh at 0..N
    logic              has_char;  // token carries a character to apply
    logic              fin;       // last item of the candidate
    logic [CHAR_W-1:0] ch;
    logic [DIST_W-1:0] left;      // new value of the previous cell
    logic [DIST_W-1:0] diag;      // old value of the previous cell
    logic [DIST_W-1:0] result;    // value of the cell at the pattern end
  } token_t;

  // Request from the candidate control to the scoring logic.
  typedef struct packed {
    logic              clear;
    logic              fin;
    logic              too_long;
    logic [DIST_W-1:0] score;
  } res_req_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic              too_long;
    logic [TIE_W-1:0]  tie_count;
    logic [DIST_W-1:0] best_distance;
    verdict_t          verdict;
    logic [DIST_W-1:0] distance;
  } result_t;

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] x);
    return (x == DIST_MAX) ? x : x + DIST_W'(1);
  endfunction

  function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/edm_cell.sv
// One dynamic-programming cell of the edit distance row, holding one pattern character.
`default_nettype none

module edm_cell #(
  parameter int INDEX = 1,
  parameter int PL_W  = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  edm_pkg::token_t       in_tok,
  input  logic [PL_W-1:0]       pat_len,
  input  logic                  pat_we,
  input  logic [PL_W-1:0]       pat_waddr,
  input  logic [edm_pkg::CHAR_W-1:0] pat_wdata,
  output logic                  out_valid,
  output edm_pkg::token_t       out_tok
);
  import edm_pkg::*;

  localparam int INIT_I = (INDEX > 127) ? 127 : INDEX;
  localparam logic [DIST_W-1:0] INIT = DIST_W'(INIT_I);

  logic [CHAR_W-1:0] pchar;
  logic [DIST_W-1:0] dp;
  logic [DIST_W-1:0] old_val;
  logic [DIST_W-1:0] sub_val;
  logic [DIST_W-1:0] new_val;
  token_t            tok_next;

  always_comb begin
    old_val = in_tok.start ? INIT : dp;
    sub_val = (pchar == in_tok.ch) ? in_tok.diag : sat_inc(in_tok.diag);
    new_val = in_tok.has_char
            ? min2(min2(sat_inc(old_val), sat_inc(in_tok.left)), sub_val)
            : old_val;
    tok_next        = in_tok;
    tok_next.left   = new_val;
    tok_next.diag   = old_val;
    tok_next.result = (pat_len == PL_W'(INDEX)) ? new_val : in_tok.result;
  end

  always_ff @(posedge clk) begin
    if (pat_we && (pat_waddr == PL_W'(INDEX - 1))) begin
      pchar <= pat_wdata;
    end
    if (in_valid && in_tok.has_char) begin
      dp <= new_val;
    end
    out_tok <= tok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/edm_result.sv
// Scoring of finished candidates against the group best, and the result output stage.
`default_nettype none
`include "assert_macros.svh"

module edm_result #(
  parameter int PL_W = 6,
  parameter int CL_W = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [edm_pkg::CFG_W-1:0]     cfg_data,
  input  edm_pkg::res_req_t             req,
  input  logic [CL_W-1:0]               cand_len,
  input  logic [PL_W-1:0]               pat_len,
  output logic                          skid_busy,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [edm_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import edm_pkg::*;

  localparam int GAP_W = (CL_W > PL_W) ? CL_W : PL_W;
  localparam int CMP_W = (GAP_W > DIST_W) ? GAP_W : DIST_W;

  logic [CFG_W-1:0]  max_dist;
  logic [DIST_W-1:0] best;
  logic [DIST_W-1:0] best_next;
  logic [TIE_W-1:0]  ties;
  logic [TIE_W-1:0]  ties_next;
  logic [CMP_W-1:0]  cl_ext;
  logic [CMP_W-1:0]  pl_ext;
  logic [CMP_W-1:0]  gap;
  verdict_t          verdict;
  result_t           res;
  logic              out_valid;
  result_t           out_q;
  logic              skid_valid;
  result_t           skid_q;

  always_comb begin
    cl_ext    = CMP_W'(cand_len);
    pl_ext    = CMP_W'(pat_len);
    gap       = (cl_ext >= pl_ext) ? cl_ext - pl_ext : pl_ext - cl_ext;
    best_next = best;
    ties_next = ties;
    verdict   = VERDICT_SKIP;
    if (req.clear) begin
      best_next = DIST_W'(max_dist) + DIST_W'(1);
      ties_next = '0;
    end else if (req.fin) begin
      priority if (req.too_long || (best == '0) || (gap >= CMP_W'(best))) begin
        verdict = VERDICT_SKIP;
      end else if (req.score < best) begin
        best_next = req.score;
        ties_next = TIE_W'(1);
        verdict   = VERDICT_BEST;
      end else if (req.score == best) begin
        ties_next = (ties < TIE_MAX) ? ties + TIE_W'(1) : ties;
        verdict   = VERDICT_TIE;
      end else begin
        verdict = VERDICT_WORSE;
      end
    end
    res = '{too_long: req.too_long, tie_count: ties_next, best_distance: best_next,
            verdict: verdict, distance: req.score};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist <= MAXD_RESET;
      best     <= BEST_RESET;
      ties     <= '0;
    end else begin
      if (cfg_we) begin
        max_dist <= cfg_data;
      end
      best <= best_next;
      ties <= ties_next;
    end
  end

  // Output register with one skid entry behind it; the skid fills only when a
  // result arrives while the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= req.fin;
        end
      end else if (req.fin) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (req.fin) begin
      skid_q <= res;
    end
  end

  assign skid_busy = skid_valid;
  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_TDATA_W'(out_q);

  `CHK_IMPL(a_skid_behind_out, skid_valid, out_valid, "skid entry full while output register is empty")
  `CHK_IMPL(a_no_fin_on_skid, req.fin, !skid_valid, "result arrived while the skid entry is full")
  `CHK_ALWAYS(a_best_range, best <= BEST_LIMIT, "group best above its largest value")

endmodule

`default_nettype wire

FILE: hdl/edit_distance_best_match_unit.sv
// Top level of the edit distance best match unit: input decode, candidate control and cell row.
`default_nettype none
`include "assert_macros.svh"

// The unit scores candidate strings against a loaded pattern by Levenshtein
// distance with unit costs and keeps the best distance of a group with a tie
// count. Items arrive on the slave stream: s_tuser selects the action (clear
// group, pattern character, candidate character) and flags an empty item,
// s_tdata holds the character and s_tlast ends the pattern or the candidate.
// The distance row lives in a chain of MAX_PATTERN cells, one per pattern
// position; each candidate character enters the first cell as a token and
// moves one cell per clock, so candidate characters are taken back to back,
// one per cycle, unless a full skid entry holds ready low. The token of a
// candidate's last item passes every cell register in turn, and then its
// result is registered in the output stage. While that token is in flight no
// other item is taken, and the input opens again once the result is
// registered. A pattern character is taken only once the chain is empty.
// Clear items and empty candidate items that are not last send no token into
// the chain. One finished result may wait in the output register and a
// second in a skid entry; a full skid entry also holds ready low. The
// max_distance register is written over the cfg channel, which is always
// ready, and takes effect at the next clear.
module edit_distance_best_match_unit #(
  parameter int MAX_PATTERN   = 32,
  parameter int MAX_CANDIDATE = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [edm_pkg::CHAR_W-1:0]        s_tdata,   // [7:0] char_value
  input  logic [edm_pkg::IN_TUSER_W-1:0]    s_tuser,   // [1:0] action, [2] empty_req
  input  logic                              s_tlast,   // last
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [6:0] distance, [8:7] verdict, [15:9] best_distance, [25:16] tie_count,
  // [26] too_long, [31:27] zero
  output logic [edm_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [edm_pkg::CFG_W-1:0]         cfg_data   // max_distance
);
  import edm_pkg::*;

  localparam int PL_W  = $clog2(MAX_PATTERN + 1);
  localparam int CL_W  = $clog2(MAX_CANDIDATE + 1);
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  // Input decode.
  action_t act;
  logic    empty;
  logic    accept;

  // Pattern and candidate control state.
  logic [PL_W-1:0]  pat_len;
  logic [PL_W-1:0]  pat_len_next;
  logic             pat_open;
  logic             pat_open_next;
  logic             cand_active;
  logic             cand_active_next;
  logic             fresh;
  logic             fresh_next;
  logic [CL_W-1:0]  cand_len;
  logic [CL_W-1:0]  cand_len_next;
  logic             overflow;
  logic             overflow_next;
  logic [CNT_W-1:0] in_flight;
  logic [CNT_W-1:0] in_flight_next;
  logic             fin_pending;
  logic             fin_pending_next;

  // Candidate item working values.
  logic             starting;
  logic [CL_W-1:0]  len_before;
  logic [CL_W-1:0]  len_after;
  logic             take_char;
  logic             issue;
  logic [PL_W-1:0]  pat_base;

  // Pattern write port broadcast to the cells.
  logic              pat_we;
  logic [PL_W-1:0]   pat_waddr;

  // Cell row.
  logic   tok_valid [0:MAX_PATTERN];
  token_t tok_data  [0:MAX_PATTERN];
  logic   chain_exit;

  res_req_t res_req;
  logic     skid_busy;

  function automatic logic [DIST_W-1:0] len_sat(input logic [CL_W-1:0] n);
    return (32'(n) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(n);
  endfunction

  assign act    = action_t'(s_tuser[1:0]);
  assign empty  = s_tuser[IN_TUSER_W-1];
  assign accept = s_tvalid && s_tready;

  // A pattern character must not change a cell while a token still needs it.
  assign s_tready  = !fin_pending && !skid_busy && ((act != ACT_PATTERN) || (in_flight == '0));
  assign cfg_ready = 1'b1;

  always_comb begin
    starting   = !cand_active;
    len_before = starting ? '0 : cand_len;
    take_char  = !empty && (len_before < CL_W'(MAX_CANDIDATE));
    len_after  = take_char ? len_before + CL_W'(1) : len_before;
    pat_base   = pat_open ? pat_len : '0;

    pat_len_next     = pat_len;
    pat_open_next    = pat_open;
    cand_active_next = cand_active;
    fresh_next       = fresh;
    cand_len_next    = cand_len;
    overflow_next    = overflow;
    pat_we           = 1'b0;
    pat_waddr        = pat_base;
    issue            = 1'b0;

    if (accept) begin
      unique case (act)
        ACT_CLEAR: begin
        end
        ACT_PATTERN: begin
          cand_active_next = 1'b0;
          pat_open_next    = !s_tlast;
          if (!empty && (pat_base < PL_W'(MAX_PATTERN))) begin
            pat_we       = 1'b1;
            pat_len_next = pat_base + PL_W'(1);
          end else begin
            pat_len_next = pat_base;
          end
        end
        ACT_CAND: begin
          // Every last item sends a token so that its result leaves the chain
          // in order behind the characters before it.
          issue            = take_char || s_tlast;
          cand_active_next = !s_tlast;
          cand_len_next    = len_after;
          overflow_next    = (starting ? 1'b0 : overflow) || (!empty && !take_char);
          fresh_next       = (starting || fresh) && !take_char;
        end
        default: begin
        end
      endcase
    end

    in_flight_next = in_flight + CNT_W'(issue) - CNT_W'(tok_valid[MAX_PATTERN]);
    if (issue && s_tlast) begin
      fin_pending_next = 1'b1;
    end else if (chain_exit) begin
      fin_pending_next = 1'b0;
    end else begin
      fin_pending_next = fin_pending;
    end
  end

  assign tok_valid[0] = issue;
  assign tok_data[0]  = '{start: starting || fresh, has_char: take_char, fin: s_tlast,
                          ch: s_tdata, left: len_sat(len_after), diag: len_sat(len_before),
                          result: len_sat(len_after)};

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len     <= '0;
      pat_open    <= 1'b0;
      cand_active <= 1'b0;
      fresh       <= 1'b0;
      cand_len    <= '0;
      overflow    <= 1'b0;
      in_flight   <= '0;
      fin_pending <= 1'b0;
    end else begin
      pat_len     <= pat_len_next;
      pat_open    <= pat_open_next;
      cand_active <= cand_active_next;
      fresh       <= fresh_next;
      cand_len    <= cand_len_next;
      overflow    <= overflow_next;
      in_flight   <= in_flight_next;
      fin_pending <= fin_pending_next;
    end
  end

  // Cell j holds row entry j and pattern character j-1.
  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    edm_cell #(
      .INDEX (j),
      .PL_W  (PL_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (tok_valid[j-1]),
      .in_tok    (tok_data[j-1]),
      .pat_len   (pat_len),
      .pat_we    (pat_we),
      .pat_waddr (pat_waddr),
      .pat_wdata (s_tdata),
      .out_valid (tok_valid[j]),
      .out_tok   (tok_data[j])
    );
  end

  assign chain_exit = tok_valid[MAX_PATTERN] && tok_data[MAX_PATTERN].fin;

  always_comb begin
    res_req.clear    = accept && (act == ACT_CLEAR);
    res_req.fin      = chain_exit;
    res_req.too_long = overflow;
    res_req.score    = overflow ? '0 : tok_data[MAX_PATTERN].result;
  end

  edm_result #(
    .PL_W (PL_W),
    .CL_W (CL_W)
  ) u_result (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .req       (res_req),
    .cand_len  (cand_len),
    .pat_len   (pat_len),
    .skid_busy (skid_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  `CHK_IMPL(a_fin_in_chain, fin_pending, in_flight != '0, "finishing token lost from the cell row")
  `CHK_IMPL(a_pattern_on_empty, accept && (act == ACT_PATTERN), in_flight == '0, "pattern write while tokens in flight")
  `CHK_IMPL(a_exit_expected, chain_exit, fin_pending, "finishing token left the row unannounced")

endmodule

`default_nettype wire

FILE: bench/edit_distance_best_match_unit_test.sv
// Self-checking stream testbench for the edit distance best match unit.
`default_nettype none

// The bench drives pattern, candidate, clear and unused items into the slave
// stream and scores every accepted item with its own Levenshtein row model.
// Each candidate's last item leaves one expected score in a queue; the
// checker pops the oldest one for every result transfer on the master stream
// and compares it field by field. The run goes through directed strings, the
// length limits, tie count saturation, a long receiver hold-off and four
// random phases with different sender gaps and receiver stalls.
module edit_distance_best_match_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import edm_pkg::*;

  localparam int PATTERN_DEPTH = 32;
  localparam int CAND_DEPTH    = 64;
  localparam int CELL_TOP      = 127;
  localparam int TIES_TOP      = 1023;
  // A candidate's last token crosses the whole cell chain before its result
  // shows up, so this many quiet cycles cover any item still in flight.
  localparam int SETTLE_CYCLES = PATTERN_DEPTH + 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 240;
  localparam int HOLD_OFF      = 600;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [CHAR_W-1:0]      s_tdata = '0;      // [7:0] char_value
  logic [IN_TUSER_W-1:0]  s_tuser = '0;      // [1:0] action, [2] empty_req
  logic                   s_tlast = 1'b0;    // last
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [6:0] distance, [8:7] verdict, [15:9] best_distance, [25:16] tie_count,
  // [26] too_long, [31:27] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;     // max_distance

  // Scoring model state: the pattern, the distance row of the candidate in
  // progress and the group best with its tie count.
  logic [CHAR_W-1:0] pat_chars [PATTERN_DEPTH];
  int                pat_len;
  bit                pat_open;
  int                cell_row [PATTERN_DEPTH+1];
  int                cand_len;
  bit                cand_on;
  bit                cand_overflow;
  int                best;
  int                ties;
  logic [CFG_W-1:0]  max_dist;

  result_t expected_scores [$];
  result_t seen;
  result_t want;

  int errors      = 0;
  int cycle_count = 0;
  int sent_items  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;

  edit_distance_best_match_unit #(
    .MAX_PATTERN  (PATTERN_DEPTH),
    .MAX_CANDIDATE(CAND_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The whole run is bounded; a hang anywhere ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver side. A pending hold-off keeps tready low for that many cycles;
  // otherwise tready drops at random according to the current stall rate.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
    $display("ERROR cycle %0d: %s is %0d, expected %0d", cycle_count, what, got, wanted);
    errors++;
  endtask

  // Every result transfer is matched against the oldest expected score.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (expected_scores.size() == 0) begin
        report_mismatch("unexpected result transfer, distance", seen.distance, 0);
      end else begin
        want = expected_scores.pop_front();
        if (seen.distance !== want.distance)
          report_mismatch("distance", seen.distance, want.distance);
        if (seen.verdict !== want.verdict)
          report_mismatch("verdict", seen.verdict, want.verdict);
        if (seen.best_distance !== want.best_distance)
          report_mismatch("best_distance", seen.best_distance, want.best_distance);
        if (seen.tie_count !== want.tie_count)
          report_mismatch("tie_count", seen.tie_count, want.tie_count);
        if (seen.too_long !== want.too_long)
          report_mismatch("too_long", seen.too_long, want.too_long);
        if (m_tdata[OUT_TDATA_W-1:$bits(result_t)] !== '0)
          report_mismatch("tdata padding", m_tdata[OUT_TDATA_W-1:$bits(result_t)], 0);
      end
    end
  end

  function automatic int bump(input int x);
    return (x >= CELL_TOP) ? CELL_TOP : x + 1;
  endfunction

  // One candidate character moves the distance row down by one line.
  function automatic void advance_row(input logic [CHAR_W-1:0] ch);
    int diag;
    int left;
    int up;
    int pick;
    int via_sub;
    if (cand_len >= CAND_DEPTH) begin
      cand_overflow = 1'b1;
      return;
    end
    cand_len++;
    diag = cell_row[0];
    left = (cand_len > CELL_TOP) ? CELL_TOP : cand_len;
    cell_row[0] = left;
    for (int j = 1; j <= pat_len; j++) begin
      up = cell_row[j];
      pick = bump(up);
      if (bump(left) < pick) pick = bump(left);
      via_sub = (pat_chars[j-1] == ch) ? diag : bump(diag);
      if (via_sub < pick) pick = via_sub;
      diag = up;
      left = pick;
      cell_row[j] = pick;
    end
  endfunction

  // Updates the model with one accepted item and queues the score that a
  // finished candidate produces.
  function automatic void score_item(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                                     input bit fin, input bit empty);
    result_t r;
    int      score_val;
    int      gap;
    case (act)
      ACT_CLEAR: begin
        best = int'(max_dist) + 1;
        ties = 0;
      end
      ACT_PATTERN: begin
        // A pattern item drops any candidate in progress without a result.
        cand_on = 1'b0;
        if (!pat_open) begin
          pat_len = 0;
          pat_open = 1'b1;
        end
        if (!empty && pat_len < PATTERN_DEPTH) begin
          pat_chars[pat_len] = ch;
          pat_len++;
        end
        if (fin) pat_open = 1'b0;
      end
      ACT_CAND: begin
        if (!cand_on) begin
          for (int j = 0; j <= pat_len; j++) cell_row[j] = j;
          cand_len = 0;
          cand_overflow = 1'b0;
          cand_on = 1'b1;
        end
        if (!empty) advance_row(ch);
        if (fin) begin
          cand_on = 1'b0;
          score_val = cand_overflow ? 0 : cell_row[pat_len];
          gap = (cand_len >= pat_len) ? cand_len - pat_len : pat_len - cand_len;
          if (cand_overflow || best == 0 || gap >= best) begin
            r.verdict = VERDICT_SKIP;
          end else if (score_val < best) begin
            best = score_val;
            ties = 1;
            r.verdict = VERDICT_BEST;
          end else if (score_val == best) begin
            if (ties < TIES_TOP) ties++;
            r.verdict = VERDICT_TIE;
          end else begin
            r.verdict = VERDICT_WORSE;
          end
          r.distance = DIST_W'(score_val);
          r.best_distance = DIST_W'(best);
          r.tie_count = TIE_W'(ties);
          r.too_long = cand_overflow;
          expected_scores.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one item after an optional random gap and waits for its transfer.
  // tvalid stays high on return, so back to back items follow without a gap.
  task automatic send_item(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                           input bit fin, input bit empty);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= {empty, act};
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    score_item(act, ch, fin, empty);
    if (act != ACT_UNUSED) sent_items++;
  endtask

  // Lets every expected score come back and any resultless item settle.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_distance(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    max_dist = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a small alphabet so that candidates share characters with the
  // pattern; now and then any byte at all.
  function automatic logic [CHAR_W-1:0] random_char();
    if ($urandom_range(3) == 0) return CHAR_W'($urandom_range(255));
    return 8'h41 + CHAR_W'($urandom_range(3));
  endfunction

  function automatic int pick_len(input int limit);
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(6);
    if (r < 95) return $urandom_range(limit / 2);
    return $urandom_range(limit + 2, limit - 2);
  endfunction

  task automatic send_pattern(input int len, input bit close);
    if (len == 0) begin
      send_item(ACT_PATTERN, CHAR_W'($urandom), close, 1'b1);
    end else begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) send_item(ACT_PATTERN, CHAR_W'($urandom), 1'b0, 1'b1);
        send_item(ACT_PATTERN, random_char(), close && (i == len - 1), 1'b0);
      end
    end
  endtask

  // Candidates mostly copy the pattern with random edits, which keeps the
  // distances near the group best.
  task automatic send_candidate(input int len, input bit close);
    logic [CHAR_W-1:0] ch;
    if (len == 0) begin
      send_item(ACT_CAND, CHAR_W'($urandom), close, 1'b1);
    end else begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) send_item(ACT_CAND, CHAR_W'($urandom), 1'b0, 1'b1);
        ch = (i < pat_len && $urandom_range(9) < 7) ? pat_chars[i] : random_char();
        send_item(ACT_CAND, ch, close && (i == len - 1), 1'b0);
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(ACT_CLEAR, 8'hFF, 1'b1, 1'b1);
    send_item(ACT_PATTERN, 8'h00, 1'b0, 1'b0);
    send_item(ACT_PATTERN, 8'h5A, 1'b0, 1'b1);   // empty item inside the pattern
    send_item(ACT_PATTERN, 8'hFF, 1'b1, 1'b0);
    send_item(ACT_CAND, 8'h00, 1'b0, 1'b0);
    send_item(ACT_CAND, 8'hFF, 1'b1, 1'b0);      // exact match becomes the best
    send_item(ACT_CAND, 8'h00, 1'b1, 1'b1);      // empty candidate, skipped after exact match
    send_item(ACT_CLEAR, 8'h00, 1'b0, 1'b0);
    send_item(ACT_CAND, 8'hFF, 1'b1, 1'b0);      // one deletion away
    send_item(ACT_CAND, 8'h01, 1'b0, 1'b0);
    send_item(ACT_CAND, 8'hFF, 1'b1, 1'b0);      // same distance adds a tie
    send_item(ACT_CAND, 8'h7F, 1'b0, 1'b0);
    send_item(ACT_CAND, 8'h80, 1'b1, 1'b0);      // worse than the best
    send_item(ACT_CAND, 8'h33, 1'b0, 1'b0);      // abandoned by the pattern below
    send_item(ACT_PATTERN, 8'hAA, 1'b1, 1'b0);   // restarts the pattern
    send_item(ACT_UNUSED, 8'hFF, 1'b1, 1'b1);    // ignored
    send_item(ACT_CAND, 8'h00, 1'b0, 1'b1);      // empty item still starts a candidate
    send_item(ACT_CAND, 8'hAA, 1'b1, 1'b0);
    send_item(ACT_CLEAR, 8'h81, 1'b1, 1'b0);
    send_item(ACT_PATTERN, 8'h00, 1'b1, 1'b1);   // empty pattern
    send_candidate(4, 1'b1);                     // length gap not below the best
    send_item(ACT_CAND, 8'hC3, 1'b1, 1'b0);
    send_item(ACT_CAND, 8'h00, 1'b1, 1'b1);
  endtask

  // Longest pattern and candidate, the pattern two bytes and a candidate one byte past
  // its limit, at the widest max_distance so that a distance of 64 still counts as a tie.
  task automatic test_long_strings();
    wait_idle();
    write_max_distance(6'd63);
    send_item(ACT_CLEAR, 8'h00, 1'b0, 1'b0);
    for (int i = 0; i < PATTERN_DEPTH + 2; i++)
      send_item(ACT_PATTERN, CHAR_W'(i), i == PATTERN_DEPTH + 1, 1'b0);
    for (int i = 0; i < CAND_DEPTH; i++)
      send_item(ACT_CAND, CHAR_W'(8'h80 + i), i == CAND_DEPTH - 1, 1'b0);
    for (int i = 0; i <= CAND_DEPTH; i++)
      send_item(ACT_CAND, CHAR_W'(i), i == CAND_DEPTH, 1'b0);
    for (int i = 0; i < CAND_DEPTH; i++)
      send_item(ACT_CAND, CHAR_W'(i), i == CAND_DEPTH - 1, 1'b0);
  endtask

  // With max_distance 0 the best starts at 1, so one substitution against a
  // one-character pattern ties every time until the count saturates.
  task automatic test_tie_saturation();
    wait_idle();
    write_max_distance(6'd0);
    send_item(ACT_PATTERN, 8'h61, 1'b1, 1'b0);
    send_item(ACT_CLEAR, 8'h00, 1'b0, 1'b0);
    repeat (TIES_TOP + 8) send_item(ACT_CAND, 8'h62, 1'b1, 1'b0);
  endtask

  // The receiver holds off while short candidates keep arriving, so the
  // output register and skid entry fill and the input must stall.
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    write_max_distance(MAXD_RESET);
    send_item(ACT_CLEAR, 8'h00, 1'b0, 1'b0);
    send_pattern(3, 1'b1);
    hold_cycles = HOLD_OFF;
    repeat (24) send_candidate($urandom_range(3), 1'b1);
  endtask

  task automatic random_step();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 6) begin
      send_item(ACT_CLEAR, CHAR_W'($urandom), $urandom_range(1), $urandom_range(1));
    end else if (r < 18) begin
      send_pattern(pick_len(PATTERN_DEPTH), 1'b1);
    end else if (r < 90) begin
      if ($urandom_range(1) == 1) begin
        len = pat_len + int'($urandom_range(4)) - 2;
        if (len < 0) len = 0;
      end else begin
        len = pick_len(CAND_DEPTH);
      end
      send_candidate(len, 1'b1);
    end else if (r < 93) begin
      send_candidate($urandom_range(1, 3), 1'b0);   // left open, continued or abandoned
    end else if (r < 95) begin
      send_pattern($urandom_range(1, 3), 1'b0);     // left open, continued later
    end else begin
      send_item(ACT_UNUSED, CHAR_W'($urandom), $urandom_range(1), $urandom_range(1));
    end
  endtask

  // Four phases: no idling, a sparse sender, a stalling receiver, and both
  // sides idling lightly; each starts from a fresh max_distance and a clear.
  task automatic test_random();
    int stop;
    int send_rates [4];
    int stall_rates [4];
    logic [CFG_W-1:0] limits [4];
    send_rates  = '{0, 83, 0, 16};
    stall_rates = '{0, 0, 83, 16};
    limits = '{CFG_W'($urandom_range(1, 6)), 6'd0, CFG_W'($urandom_range(63)), 6'd63};
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      send_idle_pct = send_rates[p];
      stall_pct = stall_rates[p];
      write_max_distance(limits[p]);
      send_item(ACT_CLEAR, CHAR_W'($urandom), $urandom_range(1), $urandom_range(1));
      send_pattern(pick_len(PATTERN_DEPTH), 1'b1);
      stop = sent_items + RANDOM_ITEMS / 4;
      while (sent_items < stop) random_step();
    end
  endtask

  initial begin
    pat_len = 0;
    pat_open = 1'b0;
    for (int j = 0; j <= PATTERN_DEPTH; j++) cell_row[j] = 0;
    cand_len = 0;
    cand_on = 1'b0;
    cand_overflow = 1'b0;
    max_dist = MAXD_RESET;
    best = int'(MAXD_RESET) + 1;
    ties = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_long_strings();
    test_tie_saturation();
    test_backpressure();
    test_random();

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/edm_pkg.sv
hdl/edm_cell.sv
hdl/edm_result.sv
hdl/edit_distance_best_match_unit.sv
bench/edit_distance_best_match_unit_test.sv
